[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check outside of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Widths, the pad character and the alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SEXTET_W  = 6;
	localparam int unsigned GROUP_D   = 3;
	localparam int unsigned RES_MAX   = 4;
	localparam int unsigned USER_W    = 2;

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [SEXTET_W-1:0] sextet_t;

	// Alphabet character for a 6-bit value.
	function automatic byte_t char_of(input sextet_t s);
		byte_t w;
		byte_t r;
		begin
			w = {2'b00, s};
			if (s < 6'd26) begin
				r = w + 8'd65;
			end else if (s < 6'd52) begin
				r = w + 8'd71;
			end else if (s < 6'd62) begin
				r = w - 8'd4;
			end else if (s == 6'd62) begin
				r = 8'h2B;
			end else begin
				r = 8'h2F;
			end
			return r;
		end
	endfunction

	// 6-bit value of a character; bit 6 is set for anything outside the alphabet.
	function automatic logic [SEXTET_W:0] sextet_of(input byte_t c);
		byte_t d;
		logic [SEXTET_W:0] r;
		begin
			d = 8'd0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				d = c - 8'd65;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				d = c - 8'd71;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				d = c + 8'd4;
			end else if (c == 8'h2B) begin
				d = 8'd62;
			end else if (c == 8'h2F) begin
				d = 8'd63;
			end else begin
				d = 8'd64;
			end
			r = d[SEXTET_W:0];
			return r;
		end
	endfunction

endpackage

[rtl/base64_stream_codec_unit.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec
// Encodes bytes to base64 text or decodes text to bytes, one byte a transfer.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the s_axis channel, s_axis_tlast closing a message.
// Results leave on m_axis one per transfer; m_axis_tlast marks the last result
// of one input transfer and m_axis_tuser carries byte_valid and message_end.
// cfg_we with cfg_wdata selects encode (0) or decode (1) and restarts the
// group; write it only while the block is idle.
// Each accepted transfer is worked out in one pass and its up to four results
// are loaded into a result register; the first result is offered in the cycle
// after acceptance. The result register drains one result a cycle while
// m_axis_tready is high, and a new transfer is taken in the cycle its last
// result leaves, or at once when it is empty. A transfer that yields no
// result loads nothing. Sustained throughput is set by that drain.
// When m_axis_tready is low the result register holds and s_axis_tready drops
// until the pending results are taken.
// Reset clears the mode to encode, empties the group and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_codec_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,       // decode_mode
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [b64sc_pkg::BYTE_W-1:0] s_axis_tdata, // [7:0] data_byte
	input  logic                      s_axis_tlast,    // message_last
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [b64sc_pkg::BYTE_W-1:0] m_axis_tdata, // [7:0] out_byte
	output logic [b64sc_pkg::USER_W-1:0] m_axis_tuser, // [0] byte_valid, [1] message_end
	output logic                      m_axis_tlast     // run_last
);
	import b64sc_pkg::*;

	// Group state
	logic        decode_mode_q;
	byte_t       st_q [GROUP_D];
	logic [1:0]  grp_cnt_q;
	logic        stopped_q;

	// Result register
	byte_t       res_byte_s1 [RES_MAX];
	logic [1:0]  res_cnt_s1;
	logic        res_end_s1;
	logic        res_mark_s1;
	logic        res_vld_s1;
	logic [1:0]  idx_q;

	// Next-state and result logic
	logic        acc;
	logic        out_xfer;
	logic        out_tail;
	logic [1:0]  cnt_nx;
	logic        stop_nx;
	logic        st_wr;
	byte_t       st_val;
	byte_t       st_n [GROUP_D];
	byte_t       res_nx [RES_MAX];
	logic [2:0]  n_nx;
	logic        mark_nx;
	logic [SEXTET_W:0] sx_in;
	byte_t       e_b0, e_b1, e_b2;
	logic [2:0]  nchar;
	sextet_t     e_sx [RES_MAX];
	logic        do_enc;

	assign out_tail      = (idx_q == res_cnt_s1);
	assign out_xfer      = res_vld_s1 && m_axis_tready;
	assign s_axis_tready = !res_vld_s1 || (m_axis_tready && out_tail);
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = res_vld_s1;
	assign m_axis_tdata  = res_byte_s1[idx_q];
	assign m_axis_tlast  = out_tail;
	assign m_axis_tuser  = {res_end_s1 && out_tail, !res_mark_s1};

	always_comb begin
		sx_in   = sextet_of(s_axis_tdata);
		cnt_nx  = grp_cnt_q;
		stop_nx = stopped_q;
		st_wr   = 1'b0;
		st_val  = s_axis_tdata;
		n_nx    = 3'd0;
		mark_nx = 1'b0;
		e_b0    = 8'd0;
		e_b1    = 8'd0;
		e_b2    = 8'd0;
		nchar   = 3'd4;
		do_enc  = 1'b0;
		for (int k = 0; k < RES_MAX; k++) begin
			res_nx[k] = 8'd0;
		end

		// First decide whether this transfer lands in the group store.
		if (!decode_mode_q) begin
			if (grp_cnt_q != 2'd2) begin
				st_wr  = 1'b1;
				cnt_nx = grp_cnt_q + 2'd1;
			end else begin
				cnt_nx = 2'd0;
			end
		end else if (!stopped_q) begin
			if (sx_in[SEXTET_W]) begin
				stop_nx = 1'b1;
			end else if (grp_cnt_q == 2'd3) begin
				cnt_nx = 2'd0;
			end else begin
				st_wr  = 1'b1;
				st_val = {2'b00, sx_in[SEXTET_W-1:0]};
				cnt_nx = grp_cnt_q + 2'd1;
			end
		end

		for (int i = 0; i < GROUP_D; i++) begin
			st_n[i] = (st_wr && grp_cnt_q == 2'(i)) ? st_val : st_q[i];
		end

		if (!decode_mode_q) begin
			if (grp_cnt_q == 2'd2) begin
				e_b0   = st_q[0];
				e_b1   = st_q[1];
				e_b2   = s_axis_tdata;
				do_enc = 1'b1;
			end else if (s_axis_tlast) begin
				// Partial group at message end: cnt+1 characters, then padding.
				e_b0   = st_n[0];
				e_b1   = (cnt_nx == 2'd2) ? st_n[1] : 8'd0;
				nchar  = {1'b0, cnt_nx} + 3'd1;
				do_enc = 1'b1;
			end
		end else if (!stopped_q && !sx_in[SEXTET_W] && grp_cnt_q == 2'd3) begin
			res_nx[0] = {st_q[0][5:0], st_q[1][5:4]};
			res_nx[1] = {st_q[1][3:0], st_q[2][5:2]};
			res_nx[2] = {st_q[2][1:0], sx_in[SEXTET_W-1:0]};
			n_nx      = 3'd3;
		end else if (s_axis_tlast && cnt_nx >= 2'd2) begin
			res_nx[0] = {st_n[0][5:0], st_n[1][5:4]};
			res_nx[1] = {st_n[1][3:0], (cnt_nx == 2'd3) ? st_n[2][5:2] : 4'd0};
			n_nx      = {1'b0, cnt_nx} - 3'd1;
		end

		e_sx[0] = e_b0[7:2];
		e_sx[1] = {e_b0[1:0], e_b1[7:4]};
		e_sx[2] = {e_b1[3:0], e_b2[7:6]};
		e_sx[3] = e_b2[5:0];
		if (do_enc) begin
			for (int k = 0; k < RES_MAX; k++) begin
				res_nx[k] = (3'(k) < nchar) ? char_of(e_sx[k]) : PAD_CHAR;
			end
			n_nx = 3'd4;
		end

		// An end transfer with nothing to say still closes the message.
		if (s_axis_tlast && n_nx == 3'd0) begin
			n_nx    = 3'd1;
			mark_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			grp_cnt_q     <= 2'd0;
			stopped_q     <= 1'b0;
		end else if (cfg_we) begin
			decode_mode_q <= cfg_wdata;
			grp_cnt_q     <= 2'd0;
			stopped_q     <= 1'b0;
		end else if (acc) begin
			grp_cnt_q <= s_axis_tlast ? 2'd0 : cnt_nx;
			stopped_q <= s_axis_tlast ? 1'b0 : stop_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !cfg_we) begin
			for (int i = 0; i < GROUP_D; i++) begin
				st_q[i] <= st_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s1 <= 1'b0;
			idx_q      <= 2'd0;
		end else if (acc && n_nx != 3'd0) begin
			res_vld_s1 <= 1'b1;
			idx_q      <= 2'd0;
		end else if (out_xfer) begin
			if (out_tail) begin
				res_vld_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_nx != 3'd0) begin
			for (int k = 0; k < RES_MAX; k++) begin
				res_byte_s1[k] <= res_nx[k];
			end
			res_cnt_s1  <= 2'(n_nx - 3'd1);
			res_end_s1  <= s_axis_tlast;
			res_mark_s1 <= mark_nx;
		end
	end

	`ASSERT_IMPLIES(a_enc_cnt, clk, arst_n, !decode_mode_q, grp_cnt_q != 2'd3, "encode group overfull")
	`ASSERT_IMPLIES(a_stop_mode, clk, arst_n, stopped_q, decode_mode_q, "stop flag set in encode mode")
	`ASSERT_IMPLIES(a_idx_range, clk, arst_n, res_vld_s1, idx_q <= res_cnt_s1, "result index past count")
	`ASSERT_NEXT(a_msg_clear, clk, arst_n, acc && s_axis_tlast && !cfg_we, grp_cnt_q == 2'd0 && !stopped_q, "group not cleared at message end")

endmodule

[tb/base64_stream_codec_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream codec checker
// Watches the configuration port and both stream channels, predicts the
// results of every accepted input transfer and compares each output transfer
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module base64_stream_codec_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [b64sc_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic                         s_axis_tlast,  // message_last
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [b64sc_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
	input  logic [b64sc_pkg::USER_W-1:0] m_axis_tuser,  // [0] byte_valid, [1] message_end
	input  logic                         m_axis_tlast,  // run_last
	output int                           mismatches,
	output int                           waiting
);
	import b64sc_pkg::*;

	typedef struct packed {
		byte_t out_byte;
		logic  byte_valid;
		logic  run_last;
		logic  message_end;
	} codec_result_t;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [SEXTET_W:0] NO_SEXTET = 7'd64;
	localparam int REPORT_MAX = 10;

	codec_result_t results_due [$];
	codec_result_t staged_results [RES_MAX];
	int            staged;

	logic  decoding;
	logic  halted;
	byte_t held [GROUP_D];
	int    held_n;

	initial mismatches = 0;

	function automatic logic [SEXTET_W:0] sextet_value(input byte_t c);
		for (int k = 0; k < 64; k++)
			if (ALPHABET[8*(63-k) +: 8] == c) return 7'(k);
		return NO_SEXTET;
	endfunction

	task automatic clear_group();
		for (int k = 0; k < GROUP_D; k++) held[k] = '0;
		held_n = 0;
		halted = 1'b0;
	endtask

	task automatic stage_result(input byte_t value, input logic ok);
		staged_results[staged] = '{out_byte: value, byte_valid: ok,
			run_last: 1'b0, message_end: 1'b0};
		staged++;
	endtask

	// Characters beyond the ones shown are padding.
	task automatic emit_chars(input int shown, input byte_t b0, input byte_t b1,
			input byte_t b2);
		sextet_t s [4];
		s[0] = b0[7:2];
		s[1] = {b0[1:0], b1[7:4]};
		s[2] = {b1[3:0], b2[7:6]};
		s[3] = b2[5:0];
		for (int k = 0; k < 4; k++)
			stage_result(k < shown ? ALPHABET[8*(63-s[k]) +: 8] : PAD_CHAR, 1'b1);
	endtask

	task automatic emit_bytes(input int count, input sextet_t a0, input sextet_t a1,
			input sextet_t a2, input sextet_t a3);
		byte_t b [3];
		b[0] = {a0, a1[5:4]};
		b[1] = {a1[3:0], a2[5:2]};
		b[2] = {a2[1:0], a3};
		for (int k = 0; k < count && k < 3; k++)
			stage_result(b[k], 1'b1);
	endtask

	task automatic predict_codec(input byte_t c, input logic fin);
		logic [SEXTET_W:0] sx;
		staged = 0;
		if (!decoding) begin
			if (held_n == 2) begin
				emit_chars(4, held[0], held[1], c);
				held_n = 0;
			end else begin
				held[held_n] = c;
				held_n++;
			end
			if (fin && held_n != 0) begin
				emit_chars(held_n + 1, held[0], held_n >= 2 ? held[1] : '0, '0);
				held_n = 0;
			end
		end else begin
			// After a pad or a foreign character, only the end of the message matters.
			if (!halted) begin
				sx = sextet_value(c);
				if (sx == NO_SEXTET) begin
					halted = 1'b1;
				end else if (held_n == 3) begin
					emit_bytes(3, held[0][5:0], held[1][5:0], held[2][5:0], sx[5:0]);
					held_n = 0;
				end else begin
					held[held_n] = {2'b00, sx[5:0]};
					held_n++;
				end
			end
			if (fin && held_n >= 2)
				emit_bytes(held_n - 1, held[0][5:0], held[1][5:0],
					held_n == 3 ? held[2][5:0] : '0, '0);
		end
		if (fin) begin
			if (staged == 0) stage_result('0, 1'b0);
			staged_results[staged-1].message_end = 1'b1;
			clear_group();
		end
		if (staged > 0) staged_results[staged-1].run_last = 1'b1;
		for (int k = 0; k < staged; k++)
			results_due.insert(results_due.size(), staged_results[k]);
	endtask

	task automatic note_mismatch(input string what, input codec_result_t want,
			input codec_result_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t %s: expected byte %02h valid %0b run_last %0b end %0b,",
				$realtime, what, want.out_byte, want.byte_valid, want.run_last,
				want.message_end,
				" got byte %02h valid %0b run_last %0b end %0b",
				got.out_byte, got.byte_valid, got.run_last, got.message_end);
	endtask

	task automatic check_result();
		codec_result_t got;
		codec_result_t want;
		got = '{out_byte: m_axis_tdata, byte_valid: m_axis_tuser[0],
			run_last: m_axis_tlast, message_end: m_axis_tuser[1]};
		if (results_due.size() == 0) begin
			note_mismatch("unexpected result", '0, got);
		end else begin
			want = results_due.pop_front();
			if (got !== want) note_mismatch("result differs", want, got);
		end
	endtask

	// Results leave no earlier than the cycle after their input, so checking before
	// predicting at the same edge keeps the queue in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoding = 1'b0;
			clear_group();
			results_due.delete();
			waiting <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) check_result();
			if (cfg_we) begin
				decoding = cfg_wdata;
				clear_group();
			end
			if (s_axis_tvalid && s_axis_tready) predict_codec(s_axis_tdata, s_axis_tlast);
			waiting <= results_due.size();
		end
	end

endmodule

[tb/base64_stream_codec_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream codec testbench
// Drives directed and random messages in both modes with random idling on
// both channels and one long output hold-off; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit_test;
	import b64sc_pkg::*;

	localparam logic ENCODE = 1'b0;
	localparam logic DECODE = 1'b1;
	localparam int HOLD_CYCLES   = 60;
	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 20;
	localparam int PHASES        = 6;
	localparam int PRESSURE_PHASE = 4;
	localparam int CALM_PHASE     = 2;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [BYTE_W-1:0]  s_axis_tdata;   // [7:0] data_byte
	logic               s_axis_tlast;   // message_last
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [BYTE_W-1:0]  m_axis_tdata;   // [7:0] out_byte
	logic [USER_W-1:0]  m_axis_tuser;   // [0] byte_valid, [1] message_end
	logic               m_axis_tlast;   // run_last

	int          mismatches;
	int          waiting;
	int          quiet_cycles;
	int unsigned sent;
	logic        decoding;
	logic        hold_req;
	logic        calm;

	base64_stream_codec_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	base64_stream_codec_checker b64_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.waiting       (waiting)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly back to back, often a short gap, now and then a long one.
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(input byte_t value, input logic fin);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		gap = idle_span();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends len characters packed right-aligned, the first one highest.
	task automatic send_chars(input logic [63:0] text, input int len);
		for (int k = 0; k < len; k++)
			send_byte(text[8*(len-1-k) +: 8], k == len - 1);
	endtask

	task automatic send_encode_message();
		int len;
		len = $urandom_range(1, 8);
		for (int k = 0; k < len; k++)
			send_byte(byte_t'($urandom_range(0, 255)), k == len - 1);
	endtask

	// Mostly well-formed text, sometimes padded; some pure noise and some
	// text broken by one stray byte.
	task automatic send_decode_message();
		int    kind;
		int    len;
		int    pads;
		int    bad_at;
		byte_t value;
		kind = $urandom_range(0, 9);
		len = $urandom_range(1, 10);
		pads = (kind < 7 && len % 4 != 0 && $urandom_range(0, 1)) ? 4 - len % 4 : 0;
		bad_at = (kind >= 8) ? $urandom_range(0, len - 1) : len;
		for (int k = 0; k < len + pads; k++) begin
			if (k >= len)
				value = PAD_CHAR;
			else if (kind == 7)
				value = byte_t'($urandom_range(0, 255));
			else if (k == bad_at)
				value = $urandom_range(0, 1) ? PAD_CHAR : byte_t'($urandom_range(0, 255));
			else
				value = char_of(sextet_t'($urandom_range(0, 63)));
			send_byte(value, k == len + pads - 1);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		decoding = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Output side: random stalls, plus one long hold-off on request so the
	// block fills up and has to stall its input.
	initial begin : sink_side
		int unsigned stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0) stall_left = idle_span();
			end
		end
	end

	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = ENCODE;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		hold_req = 1'b0;
		calm = 1'b0;
		sent = 0;
		decoding = ENCODE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Encode after reset: a full group, one- and two-byte tails, and a
		// group followed by a one-byte tail.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h4D, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'h80, 1'b1);
		drain();

		// Decode: a full group, a group plus a two-character tail, a pad that
		// stops decoding, and a single leftover character ended by a byte
		// outside the alphabet.
		set_mode(DECODE);
		send_chars("TWFu", 4);
		send_chars("/+9aAB", 6);
		send_chars("QU=x", 4);
		send_byte("z", 1'b0);
		send_byte(8'hFF, 1'b1);
		// A mode write in the middle of a message throws the partial group away.
		send_byte("Q", 1'b0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			set_mode(phase % 2 ? DECODE : ENCODE);
			calm = (phase == CALM_PHASE);
			if (phase == PRESSURE_PHASE) hold_req = 1'b1;
			base = sent;
			while (sent - base < PHASE_ITEMS) begin
				if (decoding) send_decode_message();
				else send_encode_message();
			end
			// Sometimes leave a message open across the next mode write.
			if ($urandom_range(0, 1))
				send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
			drain();
		end
		calm = 1'b0;

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
